>>> sv/ternary_cosine_similarity_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef TERNARY_COSINE_SIMILARITY_DEFINES_SVH
`define TERNARY_COSINE_SIMILARITY_DEFINES_SVH

// Checked only outside reset.
`define TCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define TCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/tcs_pkg.sv
`default_nettype none
package tcs_pkg;

    localparam int TCS_MAX_LEN = 256;
    localparam int FIFO_DEPTH  = 2;

    localparam int QUO_BITS   = 31;
    localparam int SQRT_STEPS = 16;
    localparam int SQRT_IN_W  = 2 * SQRT_STEPS;
    localparam int SREM_W     = SQRT_STEPS + 3;
    localparam int CNT_W      = 5;
    localparam int MAG_W      = 15;
    localparam int COS_W      = 16;

    localparam logic [1:0]       TRIT_ZERO = 2'd1;
    localparam logic [MAG_W-1:0] MAG_MAX   = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_back_state;

endpackage
`default_nettype wire

>>> sv/tcs_front.sv
`default_nettype none
module tcs_front #(
    parameter int  MAX_LEN = tcs_pkg::TCS_MAX_LEN,
    localparam int AW      = $clog2(MAX_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [1:0]           i_trit_a,
    input  logic [1:0]           i_trit_b,
    input  logic                 i_last,
    output logic                 o_push,
    output logic signed [AW:0]   o_dot,
    output logic [AW-1:0]        o_na,
    output logic [AW-1:0]        o_nb,
    output logic                 o_over
);
    import tcs_pkg::*;

    logic signed [AW:0] r_dot, n_dot;
    logic [AW-1:0]      r_na, n_na;
    logic [AW-1:0]      r_nb, n_nb;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic               r_over, n_over;

    logic               za, zb, room;
    logic signed [AW:0] delta;

    always_comb begin
        za   = (i_trit_a == TRIT_ZERO);
        zb   = (i_trit_b == TRIT_ZERO);
        room = (r_cnt < AW'(MAX_LEN));
        if (za || zb) begin
            delta = '0;
        end else if (i_trit_a[1] == i_trit_b[1]) begin
            delta = (AW+1)'(1);
        end else begin
            delta = -(AW+1)'(1);
        end

        if (room) begin
            o_dot = r_dot + delta;
            o_na  = r_na + AW'(!za);
            o_nb  = r_nb + AW'(!zb);
        end else begin
            o_dot = r_dot;
            o_na  = r_na;
            o_nb  = r_nb;
        end
        o_over = r_over | ~room;
        o_push = i_take & i_last;

        n_dot  = r_dot;
        n_na   = r_na;
        n_nb   = r_nb;
        n_cnt  = r_cnt;
        n_over = r_over;
        if (i_take) begin
            if (i_last) begin
                n_dot  = '0;
                n_na   = '0;
                n_nb   = '0;
                n_cnt  = '0;
                n_over = 1'b0;
            end else begin
                n_dot  = o_dot;
                n_na   = o_na;
                n_nb   = o_nb;
                n_cnt  = room ? r_cnt + AW'(1) : r_cnt;
                n_over = o_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_cnt  <= '0;
            r_over <= 1'b0;
        end else begin
            r_dot  <= n_dot;
            r_na   <= n_na;
            r_nb   <= n_nb;
            r_cnt  <= n_cnt;
            r_over <= n_over;
        end
    end

endmodule
`default_nettype wire

>>> sv/tcs_fifo.sv
`default_nettype none
`include "ternary_cosine_similarity_defines.svh"
module tcs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = tcs_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        o_data  = r_mem[r_rd];
        o_empty = (r_cnt == '0);
        o_full  = (r_cnt == CW'(DEPTH));
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    `TCS_ASSERT(a_no_push_full, i_push |-> !o_full, "push into full queue")
    `TCS_ASSERT(a_no_pop_empty, i_pop |-> !o_empty, "pop from empty queue")
    `TCS_ASSERT(a_cnt_bound, r_cnt <= CW'(DEPTH), "queue count out of range")

endmodule
`default_nettype wire

>>> sv/tcs_back.sv
`default_nettype none
`include "ternary_cosine_similarity_defines.svh"
module tcs_back #(
    parameter int  MAX_LEN = tcs_pkg::TCS_MAX_LEN,
    localparam int AW      = $clog2(MAX_LEN + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  logic signed [AW:0] i_dot,
    input  logic [AW-1:0]      i_na,
    input  logic [AW-1:0]      i_nb,
    input  logic               i_over,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [9:0]  o_dot_product,
    output logic [8:0]         o_norm_a,
    output logic [8:0]         o_norm_b,
    output logic signed [15:0] o_cosine_q15,
    output logic               o_over_length
);
    import tcs_pkg::*;

    localparam int PW = 2 * AW;
    localparam int DX = (AW + 1 > 10) ? AW + 1 : 10;
    localparam int NX = (AW > 9) ? AW : 9;

    t_back_state r_state, n_state;

    logic signed [AW:0]   r_dot, n_dot;
    logic [AW-1:0]        r_na, n_na;
    logic [AW-1:0]        r_nb, n_nb;
    logic                 r_over, n_over;
    logic [AW-1:0]        r_mag, n_mag;
    logic [PW:0]          r_rem, n_rem;
    logic [PW-1:0]        r_den, n_den;
    logic [QUO_BITS-1:0]  r_quo, n_quo;
    logic [SQRT_IN_W-1:0] r_sq, n_sq;
    logic [SREM_W-1:0]    r_srem, n_srem;
    logic [SQRT_STEPS-1:0] r_root, n_root;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    logic                 r_valid, n_valid;
    logic signed [9:0]    r_o_dot, n_o_dot;
    logic [8:0]           r_o_na, n_o_na;
    logic [8:0]           r_o_nb, n_o_nb;
    logic signed [COS_W-1:0] r_o_cos, n_o_cos;
    logic                 r_o_over, n_o_over;

    logic [PW-1:0]        clamp;
    logic [PW:0]          trial;
    logic                 ge;
    logic [SREM_W-1:0]    s_sh, s_trial;
    logic                 s_ge;
    logic [MAG_W-1:0]     fmag;
    logic signed [DX-1:0] dot_x;
    logic [NX-1:0]        na_x, nb_x;

    always_comb begin
        n_state  = r_state;
        n_dot    = r_dot;
        n_na     = r_na;
        n_nb     = r_nb;
        n_over   = r_over;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_den    = r_den;
        n_quo    = r_quo;
        n_sq     = r_sq;
        n_srem   = r_srem;
        n_root   = r_root;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_o_dot  = r_o_dot;
        n_o_na   = r_o_na;
        n_o_nb   = r_o_nb;
        n_o_cos  = r_o_cos;
        n_o_over = r_o_over;
        o_pop    = 1'b0;

        // restoring divide step; first step takes the clamped square unshifted
        clamp = (r_rem[PW-1:0] > r_den) ? r_den : r_rem[PW-1:0];
        trial = (r_cnt == CNT_W'(QUO_BITS - 1)) ? {1'b0, clamp}
                                                : {r_rem[PW-1:0], 1'b0};
        ge    = (trial >= {1'b0, r_den});

        // digit-by-digit square root step
        s_sh    = {r_srem[SREM_W-3:0], r_sq[SQRT_IN_W-1 -: 2]};
        s_trial = SREM_W'({r_root, 2'b01});
        s_ge    = (s_sh >= s_trial);

        fmag  = r_root[SQRT_STEPS-1] ? MAG_MAX : r_root[MAG_W-1:0];
        dot_x = DX'(r_dot);
        na_x  = NX'(r_na);
        nb_x  = NX'(r_nb);

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_dot   = i_dot;
                    n_na    = i_na;
                    n_nb    = i_nb;
                    n_over  = i_over;
                    n_mag   = i_dot[AW] ? AW'(-i_dot) : i_dot[AW-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_rem   = {1'b0, PW'(r_mag) * PW'(r_mag)};
                n_den   = PW'(r_na) * PW'(r_nb);
                n_cnt   = CNT_W'(QUO_BITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? trial - {1'b0, r_den} : trial;
                n_quo = {r_quo[QUO_BITS-2:0], ge};
                if (r_cnt == '0) begin
                    n_sq    = SQRT_IN_W'({r_quo[QUO_BITS-2:0], ge});
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(SQRT_STEPS - 1);
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_SQRT: begin
                n_sq   = {r_sq[SQRT_IN_W-3:0], 2'b00};
                n_srem = s_ge ? s_sh - s_trial : s_sh;
                n_root = {r_root[SQRT_STEPS-2:0], s_ge};
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                n_valid  = 1'b1;
                n_o_dot  = dot_x[9:0];
                n_o_na   = na_x[8:0];
                n_o_nb   = nb_x[8:0];
                n_o_over = r_over;
                if (r_na == '0 || r_nb == '0) begin
                    n_o_cos = '0;
                end else if (r_dot[AW]) begin
                    n_o_cos = -COS_W'(fmag);
                end else begin
                    n_o_cos = COS_W'(fmag);
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dot    <= n_dot;
        r_na     <= n_na;
        r_nb     <= n_nb;
        r_over   <= n_over;
        r_mag    <= n_mag;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_quo    <= n_quo;
        r_sq     <= n_sq;
        r_srem   <= n_srem;
        r_root   <= n_root;
        r_cnt    <= n_cnt;
        r_o_dot  <= n_o_dot;
        r_o_na   <= n_o_na;
        r_o_nb   <= n_o_nb;
        r_o_cos  <= n_o_cos;
        r_o_over <= n_o_over;
    end

    assign o_valid       = r_valid;
    assign o_dot_product = r_o_dot;
    assign o_norm_a      = r_o_na;
    assign o_norm_b      = r_o_nb;
    assign o_cosine_q15  = r_o_cos;
    assign o_over_length = r_o_over;

    `TCS_ASSERT(a_single_strobe, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `TCS_ASSERT(a_cos_clamped, o_valid |-> o_cosine_q15 != 16'sh8000, "cosine not clamped")
    `TCS_ASSERT(a_pop_in_idle, o_pop |-> r_state == S_IDLE, "queue read outside idle")

endmodule
`default_nettype wire

>>> sv/ternary_cosine_similarity.sv
`default_nettype none
// Ternary cosine similarity.
// Input: one trit pair per item, taken on a clock edge with start high and
// busy low. i_last_element closes the vector pair. Trit code 3 counts as 2.
// Elements after MAX_LEN in one vector are dropped and set o_over_length.
// Output: one result per vector pair, held on the o_ ports for exactly one
// cycle with o_valid high; the receiver cannot stall.
// Result path, after the edge that takes the last element: queue write,
// queue read, a multiply step, the restoring divide, the square root, and
// the output register that raises the strobe. Input rate: one element
// per cycle while busy is low. The divide/root unit handles one vector pair
// at a time; a two-entry queue sits in front of it, and busy rises while
// that queue is full, so runs of short vectors are paced by the unit.
// Reset (synchronous, active low) clears the accumulators, the queue and
// the sequencer; no result is pending afterwards.
module ternary_cosine_similarity #(
    parameter int MAX_LEN = tcs_pkg::TCS_MAX_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_trit_a,
    input  logic [1:0]         i_trit_b,
    input  logic               i_last_element,
    output logic               o_valid,
    output logic signed [9:0]  o_dot_product,
    output logic [8:0]         o_norm_a,
    output logic [8:0]         o_norm_b,
    output logic signed [15:0] o_cosine_q15,
    output logic               o_over_length
);
    import tcs_pkg::*;

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int QW = 3 * AW + 2;

    logic               take;
    logic               push, pop, q_empty, q_full;
    logic signed [AW:0] f_dot, b_dot;
    logic [AW-1:0]      f_na, f_nb, b_na, b_nb;
    logic               f_over, b_over;
    logic [QW-1:0]      q_in, q_out;

    assign take = start & ~busy;
    assign busy = q_full;
    assign q_in = {f_dot, f_na, f_nb, f_over};
    assign {b_dot, b_na, b_nb, b_over} = q_out;

    tcs_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_trit_a (i_trit_a),
        .i_trit_b (i_trit_b),
        .i_last   (i_last_element),
        .o_push   (push),
        .o_dot    (f_dot),
        .o_na     (f_na),
        .o_nb     (f_nb),
        .o_over   (f_over)
    );

    tcs_fifo #(
        .W     (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tcs_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_dot         (b_dot),
        .i_na          (b_na),
        .i_nb          (b_nb),
        .i_over        (b_over),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_dot_product (o_dot_product),
        .o_norm_a      (o_norm_a),
        .o_norm_b      (o_norm_b),
        .o_cosine_q15  (o_cosine_q15),
        .o_over_length (o_over_length)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb_ternary_cosine_similarity.sv
`timescale 1ns / 1ps

module tb_ternary_cosine_similarity;
    import tcs_pkg::*;

    localparam int MAX_LEN     = TCS_MAX_LEN;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 60;

    localparam logic [1:0] TRIT_NEG = 2'd0;
    localparam logic [1:0] TRIT_POS = 2'd2;
    localparam logic [1:0] TRIT_SAT = 2'd3;

    typedef enum int {
        MIX_RANDOM,
        MIX_ALIKE,
        MIX_OPPOSITE,
        MIX_SPARSE
    } t_mix;

    typedef struct {
        logic signed [9:0]  dot;
        logic [8:0]         na;
        logic [8:0]         nb;
        logic signed [15:0] cos;
        logic               ovf;
    } t_similarity;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic [1:0]         i_trit_a       = TRIT_ZERO;
    logic [1:0]         i_trit_b       = TRIT_ZERO;
    logic               i_last_element = 1'b0;
    logic               busy;
    logic               o_valid;
    logic signed [9:0]  o_dot_product;
    logic [8:0]         o_norm_a;
    logic [8:0]         o_norm_b;
    logic signed [15:0] o_cosine_q15;
    logic               o_over_length;

    t_similarity pending_results[$];

    int acc_dot;
    int acc_na;
    int acc_nb;
    int elem_count;
    bit overflow_seen;

    int idle_pct          = 8;
    int items_sent        = 0;
    int results_predicted = 0;
    int results_checked   = 0;
    int over_length_seen  = 0;
    int mismatches        = 0;
    int quiet_cycles      = 0;

    ternary_cosine_similarity DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_trit_a       (i_trit_a),
        .i_trit_b       (i_trit_b),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .o_dot_product  (o_dot_product),
        .o_norm_a       (o_norm_a),
        .o_norm_b       (o_norm_b),
        .o_cosine_q15   (o_cosine_q15),
        .o_over_length  (o_over_length)
    );

    always #2 i_clk = ~i_clk;

    function automatic int centered(input logic [1:0] code);
        if (code == TRIT_SAT) begin
            return 1;
        end
        return int'(code) - int'(TRIT_ZERO);
    endfunction

    function automatic logic signed [15:0] cosine_q15_of(input int dot, input int na,
                                                          input int nb);
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned root;
        longint unsigned trial;
        int              signed_mag;
        if (na == 0 || nb == 0) begin
            return '0;
        end
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        sq  = mag * mag;
        den = longint'(na) * longint'(nb);
        if (sq > den) begin
            sq = den;
        end
        quo  = (sq << 30) / den;
        root = 0;
        for (int k = 16; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= quo) begin
                root = trial;
            end
        end
        if (root > 32767) begin
            root = 32767;
        end
        signed_mag = int'(root);
        return (dot < 0) ? 16'(-signed_mag) : 16'(signed_mag);
    endfunction

    task automatic clear_sums();
        acc_dot       = 0;
        acc_na        = 0;
        acc_nb        = 0;
        elem_count    = 0;
        overflow_seen = 1'b0;
    endtask

    task automatic accumulate_pair(input logic [1:0] a, input logic [1:0] b, input logic last);
        int          ca;
        int          cb;
        t_similarity want;
        ca = centered(a);
        cb = centered(b);
        if (elem_count < MAX_LEN) begin
            acc_dot += ca * cb;
            acc_na  += ca * ca;
            acc_nb  += cb * cb;
            elem_count++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (last) begin
            want.dot = acc_dot[9:0];
            want.na  = acc_na[8:0];
            want.nb  = acc_nb[8:0];
            want.cos = cosine_q15_of(acc_dot, acc_na, acc_nb);
            want.ovf = overflow_seen;
            pending_results.push_back(want);
            results_predicted++;
            clear_sums();
        end
    endtask

    task automatic send_pair(input logic [1:0] a, input logic [1:0] b, input logic last);
        start          <= 1'b1;
        i_trit_a       <= a;
        i_trit_b       <= b;
        i_last_element <= last;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        accumulate_pair(a, b, last);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_vector(input int len, input t_mix mix);
        logic [1:0] a;
        logic [1:0] b;
        for (int n = 0; n < len; n++) begin
            a = 2'($urandom_range(3));
            b = 2'($urandom_range(3));
            case (mix)
                MIX_ALIKE: begin
                    if ($urandom_range(7) != 0) begin
                        b = a;
                    end
                end
                MIX_OPPOSITE: begin
                    if ($urandom_range(7) != 0) begin
                        b = (centered(a) > 0) ? TRIT_NEG : (a == TRIT_NEG) ? TRIT_POS : a;
                    end
                end
                MIX_SPARSE: begin
                    if ($urandom_range(1) != 0) begin
                        a = TRIT_ZERO;
                    end
                    if ($urandom_range(1) != 0) begin
                        b = TRIT_ZERO;
                    end
                end
                default: begin
                end
            endcase
            send_pair(a, b, n == len - 1);
        end
    endtask

    // every (a, b) code pair in one vector, saturating code included
    task automatic test_trit_codes();
        for (int n = 0; n < 16; n++) begin
            send_pair(2'(n >> 2), 2'(n), n == 15);
        end
    endtask

    task automatic test_zero_norm();
        send_pair(TRIT_ZERO, TRIT_POS, 1'b0);
        send_pair(TRIT_ZERO, TRIT_SAT, 1'b1);
        send_pair(TRIT_NEG, TRIT_ZERO, 1'b1);
    endtask

    task automatic test_full_correlation();
        send_pair(TRIT_POS, TRIT_POS, 1'b0);
        send_pair(TRIT_SAT, TRIT_POS, 1'b0);
        send_pair(TRIT_NEG, TRIT_NEG, 1'b1);
        send_pair(TRIT_NEG, TRIT_POS, 1'b0);
        send_pair(TRIT_SAT, TRIT_NEG, 1'b1);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        for (int v = 0; v < 40; v++) begin
            send_vector($urandom_range(1, 3), t_mix'($urandom_range(3)));
        end
        idle_pct = 8;
    endtask

    task automatic test_over_length();
        for (int n = 0; n < MAX_LEN; n++) begin
            send_pair(TRIT_POS, TRIT_SAT, n == MAX_LEN - 1);
        end
        for (int n = 0; n <= MAX_LEN; n++) begin
            send_pair(TRIT_POS, TRIT_NEG, n == MAX_LEN);
        end
        send_vector(MAX_LEN + $urandom_range(2, 6), MIX_RANDOM);
    endtask

    task automatic test_random_vectors(input int item_goal, input int result_goal);
        int pick;
        int len;
        int results_at_start;
        results_at_start = results_predicted;
        while (items_sent < item_goal || results_predicted - results_at_start < result_goal) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(1, 24);
            end else if (pick < 96) begin
                len = $urandom_range(25, 80);
            end else begin
                len = $urandom_range(MAX_LEN - 40, MAX_LEN);
            end
            send_vector(len, t_mix'($urandom_range(3)));
        end
    endtask

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_similarity want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: dot %0d cos %0d", o_dot_product, o_cosine_q15);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("dot_product", int'(want.dot), int'(o_dot_product));
                check_field("norm_a", int'(want.na), int'(o_norm_a));
                check_field("norm_b", int'(want.nb), int'(o_norm_b));
                check_field("cosine_q15", int'(want.cos), int'(o_cosine_q15));
                check_field("over_length", int'(want.ovf), int'(o_over_length));
                results_checked++;
                if (o_over_length) begin
                    over_length_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles without progress", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        clear_sums();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_trit_codes();
        test_zero_norm();
        test_full_correlation();
        test_back_to_back();
        test_over_length();
        test_random_vectors(1850, 20);

        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d trit pairs sent, %0d vector results checked", items_sent, results_checked);
        $display("%0d results flagged over length; codes 0..3, zero norms, +/-full correlation",
                 over_length_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
